// ===== hw/rtl/ehs_pkg.sv =====
package ehs_pkg;

	localparam int MAX_DEPTH    = 10;
	localparam int BUCKET_SLOTS = 8;
	localparam int DIR_ENTRIES  = 1 << MAX_DEPTH;
	localparam int DIR_W        = MAX_DEPTH;
	localparam int SLOT_W       = 3;
	localparam int FILL_W       = 4;
	localparam int DEPTH_W      = 4;
	localparam int KEY_W        = 64;
	localparam int KEYS_W       = 14;
	localparam int BKTS_W       = 11;
	localparam int CNT_W        = DIR_W + 1;
	localparam int SLOT_ADDR_W  = DIR_W + SLOT_W;

	typedef enum logic [2:0] {
		ST_MISS     = 3'd0,
		ST_HIT      = 3'd1,
		ST_INSERTED = 3'd2,
		ST_DUP      = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_ACCEPT,
		OP_DIR_HASH,
		OP_BKT_RD,
		OP_BKT_CAP,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_APPEND,
		OP_DBL_INIT,
		OP_DBL_RD,
		OP_DBL_WR,
		OP_ALLOC1,
		OP_ALLOC2,
		OP_REDIR,
		OP_RD_KEY,
		OP_RD_TDIR,
		OP_RD_TFILL,
		OP_APPEND_T,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DIR,
		S_BKT,
		S_CAP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_CHECK,
		S_SPLIT,
		S_DBL_RD,
		S_DBL_WR,
		S_SPLIT2,
		S_ALLOC2,
		S_REDIR,
		S_RD_KEY,
		S_RD_TDIR,
		S_RD_TFILL,
		S_APPEND_T,
		S_RESULT
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_more;
		logic found;
		logic is_insert;
		logic fill_ge_cap;
		logic ld_ge_gd;
		logic gd_max;
		logic bkt_full;
		logic dbl_last;
		logic redir_last;
		logic redist_more;
		logic out_busy;
	} stat_t;

endpackage

// ===== hw/rtl/ehs_req_if.sv =====
interface ehs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic signed [63:0]          key;
	logic [ehs_pkg::DIR_W-1:0]   key_hash;

	modport source (output valid, output opcode, output key, output key_hash, input ready);
	modport sink (input valid, input opcode, input key, input key_hash, output ready);
endinterface

// ===== hw/rtl/ehs_rsp_if.sv =====
interface ehs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [ehs_pkg::KEYS_W-1:0]    key_total;
	logic [ehs_pkg::BKTS_W-1:0]    bucket_total;
	logic [ehs_pkg::DEPTH_W-1:0]   directory_depth;

	modport source (output valid, output status, output key_total, output bucket_total,
		output directory_depth, input ready);
	modport sink (input valid, input status, input key_total, input bucket_total,
		input directory_depth, output ready);
endinterface

// ===== hw/rtl/extendible_hash_set_unit.sv =====
// An item reads the directory and scans its bucket. An insert into a full bucket splits it:
// the directory doubles first when the bucket's depth equals the global depth, then the
// directory entries are redirected and the bucket's keys redistributed, and the insert retries.
// The unit takes one item at a time; the next input transfer can follow in the cycle after the
// result is loaded.
// Reset is asynchronous, active low; then a clearing pass over the directory runs with input closed.
module extendible_hash_set_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	ehs_req_if.sink    in,
	ehs_rsp_if.source  out
);

	// The controller sequences one item through the memories; the datapath holds
	// the directory, the bucket tables, the key store and the counters.
	ehs_pkg::cmd_t  cmd;
	ehs_pkg::stat_t stat;
	logic           in_ready;

	ehs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// A transfer on the input channel only happens in the idle state, so the
	// payload is latched at that edge and not looked at again.
	assign in.ready = in_ready;

	ehs_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_opcode        (in.opcode),
		.in_key           (in.key),
		.in_hash          (in.key_hash),
		.out_ready        (out.ready),
		.out_valid        (out.valid),
		.out_status       (out.status),
		.out_key_total    (out.key_total),
		.out_bucket_total (out.bucket_total),
		.out_depth        (out.directory_depth),
		.cmd              (cmd),
		.stat             (stat)
	);

endmodule

// ===== hw/rtl/ehs_ctrl.sv =====
module ehs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ehs_pkg::stat_t stat,
	output ehs_pkg::cmd_t  cmd
);

	ehs_pkg::state_t  state_q, state_d;
	ehs_pkg::status_t code_q, code_d;
	logic             phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ehs_pkg::S_CLEAR;
			code_q  <= ehs_pkg::ST_MISS;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		phase_d  = phase_q;
		cmd.op   = ehs_pkg::OP_NOP;
		cmd.code = code_q;
		in_ready = 1'b0;
		case (state_q)
			ehs_pkg::S_CLEAR: begin
				cmd.op = ehs_pkg::OP_CLEAR;
				if (stat.clr_last) state_d = ehs_pkg::S_IDLE;
			end
			ehs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = ehs_pkg::OP_ACCEPT;
					phase_d = 1'b0;
					state_d = ehs_pkg::S_DIR;
				end
			end
			ehs_pkg::S_DIR: begin
				cmd.op  = ehs_pkg::OP_DIR_HASH;
				state_d = ehs_pkg::S_BKT;
			end
			ehs_pkg::S_BKT: begin
				cmd.op  = ehs_pkg::OP_BKT_RD;
				state_d = ehs_pkg::S_CAP;
			end
			ehs_pkg::S_CAP: begin
				cmd.op  = ehs_pkg::OP_BKT_CAP;
				state_d = phase_q ? ehs_pkg::S_CHECK : ehs_pkg::S_SCAN_RD;
			end
			ehs_pkg::S_SCAN_RD: begin
				if (stat.scan_more) begin
					cmd.op  = ehs_pkg::OP_SCAN_RD;
					state_d = ehs_pkg::S_SCAN_CMP;
				end else begin
					state_d = ehs_pkg::S_DECIDE;
				end
			end
			ehs_pkg::S_SCAN_CMP: begin
				cmd.op  = ehs_pkg::OP_SCAN_CMP;
				state_d = ehs_pkg::S_SCAN_RD;
			end
			ehs_pkg::S_DECIDE: begin
				if (!stat.is_insert) begin
					code_d  = stat.found ? ehs_pkg::ST_HIT : ehs_pkg::ST_MISS;
					state_d = ehs_pkg::S_RESULT;
				end else if (stat.found) begin
					code_d  = ehs_pkg::ST_DUP;
					state_d = ehs_pkg::S_RESULT;
				end else begin
					phase_d = 1'b1;
					state_d = ehs_pkg::S_CHECK;
				end
			end
			ehs_pkg::S_CHECK: begin
				if (stat.fill_ge_cap) begin
					state_d = ehs_pkg::S_SPLIT;
				end else begin
					cmd.op  = ehs_pkg::OP_APPEND;
					code_d  = ehs_pkg::ST_INSERTED;
					state_d = ehs_pkg::S_RESULT;
				end
			end
			ehs_pkg::S_SPLIT: begin
				if (!stat.ld_ge_gd) begin
					state_d = ehs_pkg::S_SPLIT2;
				end else if (stat.gd_max) begin
					code_d  = ehs_pkg::ST_FULL;
					state_d = ehs_pkg::S_RESULT;
				end else begin
					cmd.op  = ehs_pkg::OP_DBL_INIT;
					state_d = ehs_pkg::S_DBL_RD;
				end
			end
			ehs_pkg::S_DBL_RD: begin
				cmd.op  = ehs_pkg::OP_DBL_RD;
				state_d = ehs_pkg::S_DBL_WR;
			end
			ehs_pkg::S_DBL_WR: begin
				cmd.op  = ehs_pkg::OP_DBL_WR;
				state_d = stat.dbl_last ? ehs_pkg::S_SPLIT2 : ehs_pkg::S_DBL_RD;
			end
			ehs_pkg::S_SPLIT2: begin
				if (stat.bkt_full) begin
					code_d  = ehs_pkg::ST_FULL;
					state_d = ehs_pkg::S_RESULT;
				end else begin
					cmd.op  = ehs_pkg::OP_ALLOC1;
					state_d = ehs_pkg::S_ALLOC2;
				end
			end
			ehs_pkg::S_ALLOC2: begin
				cmd.op  = ehs_pkg::OP_ALLOC2;
				state_d = ehs_pkg::S_REDIR;
			end
			ehs_pkg::S_REDIR: begin
				cmd.op = ehs_pkg::OP_REDIR;
				if (stat.redir_last) state_d = ehs_pkg::S_RD_KEY;
			end
			ehs_pkg::S_RD_KEY: begin
				if (stat.redist_more) begin
					cmd.op  = ehs_pkg::OP_RD_KEY;
					state_d = ehs_pkg::S_RD_TDIR;
				end else begin
					state_d = ehs_pkg::S_DIR;
				end
			end
			ehs_pkg::S_RD_TDIR: begin
				cmd.op  = ehs_pkg::OP_RD_TDIR;
				state_d = ehs_pkg::S_RD_TFILL;
			end
			ehs_pkg::S_RD_TFILL: begin
				cmd.op  = ehs_pkg::OP_RD_TFILL;
				state_d = ehs_pkg::S_APPEND_T;
			end
			ehs_pkg::S_APPEND_T: begin
				cmd.op  = ehs_pkg::OP_APPEND_T;
				state_d = ehs_pkg::S_RD_KEY;
			end
			ehs_pkg::S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.op  = ehs_pkg::OP_RESULT;
					state_d = ehs_pkg::S_IDLE;
				end
			end
			default: state_d = ehs_pkg::S_CLEAR;
		endcase
	end

endmodule

// ===== hw/rtl/ehs_dpath.sv =====
module ehs_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [3:0]                  cfg_wdata,
	input  logic                        in_opcode,
	input  logic [ehs_pkg::KEY_W-1:0]   in_key,
	input  logic [ehs_pkg::DIR_W-1:0]   in_hash,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [2:0]                  out_status,
	output logic [ehs_pkg::KEYS_W-1:0]  out_key_total,
	output logic [ehs_pkg::BKTS_W-1:0]  out_bucket_total,
	output logic [ehs_pkg::DEPTH_W-1:0] out_depth,
	input  ehs_pkg::cmd_t               cmd,
	output ehs_pkg::stat_t              stat
);

	localparam int DW = ehs_pkg::DIR_W;
	localparam int FW = ehs_pkg::FILL_W;
	localparam int GW = ehs_pkg::DEPTH_W;
	localparam int CW = ehs_pkg::CNT_W;
	localparam int AW = ehs_pkg::SLOT_ADDR_W;
	localparam int SW = ehs_pkg::SLOT_W;
	localparam int KW = ehs_pkg::KEY_W;

	// Memories.
	logic [DW-1:0] dir_mem   [ehs_pkg::DIR_ENTRIES];
	logic [GW-1:0] ld_mem    [ehs_pkg::DIR_ENTRIES];
	logic [DW-1:0] fa_mem    [ehs_pkg::DIR_ENTRIES];
	logic [FW-1:0] fill_mem  [ehs_pkg::DIR_ENTRIES];
	logic [KW-1:0] key_mem   [ehs_pkg::DIR_ENTRIES * ehs_pkg::BUCKET_SLOTS];
	logic [DW-1:0] hash_mem  [ehs_pkg::DIR_ENTRIES * ehs_pkg::BUCKET_SLOTS];

	logic          dir_we, ld_we, fa_we, fill_we, key_we;
	logic [DW-1:0] dir_wa, dir_ra, dir_wd, bk_ra;
	logic [DW-1:0] ld_wa, fa_wa, fa_wd, fill_wa, fill_ra;
	logic [GW-1:0] ld_wd;
	logic [FW-1:0] fill_wd;
	logic [AW-1:0] key_wa, key_ra;
	logic [KW-1:0] key_wd;
	logic [DW-1:0] hash_wd;

	logic [DW-1:0] dir_rd_q, ld_fa_dummy;
	logic [GW-1:0] ld_rd_q;
	logic [DW-1:0] fa_rd_q;
	logic [FW-1:0] fill_rd_q;
	logic [KW-1:0] key_rd_q;
	logic [DW-1:0] hash_rd_q;

	// Architectural and working registers.
	logic [GW-1:0] gd_q;
	logic [ehs_pkg::BKTS_W-1:0] nbk_q;
	logic [ehs_pkg::KEYS_W-1:0] nkey_q;
	logic [3:0]    cap_q;
	logic          op_q, found_q;
	logic [KW-1:0] key_q, tk_q;
	logic [DW-1:0] hash_q, th_q, b_q, nb_q, tb_q, fa_q;
	logic [FW-1:0] fill_q, i_q;
	logic [GW-1:0] ld_q;
	logic [CW-1:0] p_q;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [ehs_pkg::KEYS_W-1:0]  out_keys_q;
	logic [ehs_pkg::BKTS_W-1:0]  out_bkts_q;
	logic [GW-1:0] out_depth_q;

	logic [DW-1:0] gmask, suffix, low_mask;
	logic [CW-1:0] dsize, rcount;
	logic [GW-1:0] nd;
	logic [FW-1:0] cap_eff;

	assign gmask    = DW'((CW'(1) << gd_q) - CW'(1));
	assign dsize    = CW'(1) << gd_q;
	assign nd       = ld_q + GW'(1);
	assign low_mask = DW'((CW'(1) << ld_q) - CW'(1));
	assign suffix   = DW'(CW'(1) << ld_q) | (fa_q & low_mask);
	assign rcount   = CW'(1) << (gd_q - nd);
	assign ld_fa_dummy = '0;

	always_comb begin
		if (cap_q == 4'd0) cap_eff = FW'(1);
		else if (cap_q > 4'(ehs_pkg::BUCKET_SLOTS)) cap_eff = FW'(ehs_pkg::BUCKET_SLOTS);
		else cap_eff = cap_q;
	end

	always_comb begin
		stat.clr_last    = (p_q == CW'(ehs_pkg::DIR_ENTRIES - 1));
		stat.scan_more   = (i_q < fill_q) && (i_q < FW'(ehs_pkg::BUCKET_SLOTS));
		stat.found       = found_q;
		stat.is_insert   = op_q;
		stat.fill_ge_cap = (fill_q >= cap_eff);
		stat.ld_ge_gd    = (ld_q >= gd_q);
		stat.gd_max      = (gd_q >= GW'(ehs_pkg::MAX_DEPTH));
		stat.bkt_full    = (nbk_q >= ehs_pkg::BKTS_W'(ehs_pkg::DIR_ENTRIES));
		stat.dbl_last    = (p_q == dsize - CW'(1));
		stat.redir_last  = (p_q == rcount - CW'(1));
		stat.redist_more = (i_q < fill_q) && (i_q < FW'(ehs_pkg::BUCKET_SLOTS));
		stat.out_busy    = out_valid_q && !out_ready;
	end

	// Address and write-enable selection per micro-operation.
	always_comb begin
		dir_we  = 1'b0; dir_wa = '0; dir_wd = '0; dir_ra = '0;
		ld_we   = 1'b0; ld_wa  = '0; ld_wd  = '0;
		fa_we   = 1'b0; fa_wa  = '0; fa_wd  = '0;
		fill_we = 1'b0; fill_wa = '0; fill_wd = '0;
		bk_ra   = dir_rd_q;
		fill_ra = dir_rd_q;
		key_we  = 1'b0; key_wa = '0; key_wd = '0; hash_wd = '0;
		key_ra  = {b_q, i_q[SW-1:0]};
		case (cmd.op)
			ehs_pkg::OP_CLEAR: begin
				dir_we  = 1'b1; dir_wa = p_q[DW-1:0]; dir_wd = ld_fa_dummy;
				ld_we   = 1'b1; ld_wa  = p_q[DW-1:0];
				fa_we   = 1'b1; fa_wa  = p_q[DW-1:0];
				fill_we = 1'b1; fill_wa = p_q[DW-1:0];
			end
			ehs_pkg::OP_DIR_HASH: dir_ra = hash_q & gmask;
			ehs_pkg::OP_APPEND: begin
				key_we  = 1'b1; key_wa = {b_q, fill_q[SW-1:0]};
				key_wd  = key_q; hash_wd = hash_q;
				fill_we = 1'b1; fill_wa = b_q; fill_wd = fill_q + FW'(1);
			end
			ehs_pkg::OP_DBL_RD: dir_ra = p_q[DW-1:0];
			ehs_pkg::OP_DBL_WR: begin
				dir_we = 1'b1; dir_wa = DW'(p_q | dsize); dir_wd = dir_rd_q;
			end
			ehs_pkg::OP_ALLOC1: begin
				ld_we   = 1'b1; ld_wa = b_q; ld_wd = nd;
				fa_we   = 1'b1; fa_wa = nbk_q[DW-1:0]; fa_wd = suffix;
				fill_we = 1'b1; fill_wa = nbk_q[DW-1:0]; fill_wd = '0;
			end
			ehs_pkg::OP_ALLOC2: begin
				ld_we   = 1'b1; ld_wa = nb_q; ld_wd = nd;
				fill_we = 1'b1; fill_wa = b_q; fill_wd = '0;
			end
			ehs_pkg::OP_REDIR: begin
				dir_we = 1'b1; dir_wa = DW'(p_q << nd) | suffix; dir_wd = nb_q;
			end
			ehs_pkg::OP_RD_TDIR: dir_ra = hash_rd_q & gmask;
			ehs_pkg::OP_APPEND_T: begin
				if (fill_rd_q < FW'(ehs_pkg::BUCKET_SLOTS)) begin
					key_we  = 1'b1; key_wa = {tb_q, fill_rd_q[SW-1:0]};
					key_wd  = tk_q; hash_wd = th_q;
					fill_we = 1'b1; fill_wa = tb_q; fill_wd = fill_rd_q + FW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dir_we) dir_mem[dir_wa] <= dir_wd;
		dir_rd_q <= dir_mem[dir_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we) ld_mem[ld_wa] <= ld_wd;
		ld_rd_q <= ld_mem[bk_ra];
	end

	always_ff @(posedge clk) begin
		if (fa_we) fa_mem[fa_wa] <= fa_wd;
		fa_rd_q <= fa_mem[bk_ra];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_wa] <= fill_wd;
		fill_rd_q <= fill_mem[fill_ra];
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (key_we) hash_mem[key_wa] <= hash_wd;
		hash_rd_q <= hash_mem[key_ra];
	end

	// Control-visible registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gd_q        <= '0;
			nbk_q       <= ehs_pkg::BKTS_W'(1);
			nkey_q      <= '0;
			cap_q       <= 4'd4;
			p_q         <= '0;
			i_q         <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.op == ehs_pkg::OP_RESULT) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				ehs_pkg::OP_CLEAR: p_q <= p_q + CW'(1);
				ehs_pkg::OP_ACCEPT: found_q <= 1'b0;
				ehs_pkg::OP_BKT_RD: i_q <= '0;
				ehs_pkg::OP_SCAN_RD: i_q <= i_q + FW'(1);
				ehs_pkg::OP_SCAN_CMP: if (key_rd_q == key_q) found_q <= 1'b1;
				ehs_pkg::OP_APPEND: nkey_q <= nkey_q + ehs_pkg::KEYS_W'(1);
				ehs_pkg::OP_DBL_INIT: p_q <= '0;
				ehs_pkg::OP_DBL_WR: begin
					p_q <= p_q + CW'(1);
					if (p_q == dsize - CW'(1)) gd_q <= gd_q + GW'(1);
				end
				ehs_pkg::OP_ALLOC1: begin
					nbk_q <= nbk_q + ehs_pkg::BKTS_W'(1);
					p_q   <= '0;
				end
				ehs_pkg::OP_ALLOC2: i_q <= '0;
				ehs_pkg::OP_REDIR: p_q <= p_q + CW'(1);
				ehs_pkg::OP_RD_KEY: i_q <= i_q + FW'(1);
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			ehs_pkg::OP_ACCEPT: begin
				op_q   <= in_opcode;
				key_q  <= in_key;
				hash_q <= in_hash;
			end
			ehs_pkg::OP_BKT_RD: b_q <= dir_rd_q;
			ehs_pkg::OP_BKT_CAP: begin
				fill_q <= fill_rd_q;
				ld_q   <= ld_rd_q;
				fa_q   <= fa_rd_q;
			end
			ehs_pkg::OP_ALLOC1: nb_q <= nbk_q[DW-1:0];
			ehs_pkg::OP_RD_TDIR: begin
				tk_q <= key_rd_q;
				th_q <= hash_rd_q;
			end
			ehs_pkg::OP_RD_TFILL: tb_q <= dir_rd_q;
			ehs_pkg::OP_RESULT: begin
				out_status_q <= cmd.code;
				out_keys_q   <= nkey_q;
				out_bkts_q   <= nbk_q;
				out_depth_q  <= gd_q;
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_key_total    = out_keys_q;
	assign out_bucket_total = out_bkts_q;
	assign out_depth        = out_depth_q;

endmodule

// ===== hw/rtl/ehs_checker.sv =====
module ehs_sva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_status,
	input logic [13:0] out_key_total,
	input logic [10:0] out_bucket_total,
	input logic [3:0]  out_directory_depth
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status)
		&& $stable(out_key_total))
		else $error("result changed while stalled");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= 3'd4 && out_directory_depth <= 4'd10)
		else $error("result code or depth out of range");

	// The key total never exceeds eight times the bucket total, which lies between 1 and 1024.
	a_density: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_bucket_total != 11'd0 && out_bucket_total <= 11'd1024
		&& {3'b000, out_key_total} <= {out_bucket_total, 3'b000} + 14'd0)
		else $error("key and bucket totals inconsistent");

	// The clearing pass keeps the input closed right after reset.
	a_clear: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("input open during clearing pass");

endmodule

bind extendible_hash_set_unit ehs_sva_checker u_ehs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_ready            (in.ready),
	.out_valid           (out.valid),
	.out_ready           (out.ready),
	.out_status          (out.status),
	.out_key_total       (out.key_total),
	.out_bucket_total    (out.bucket_total),
	.out_directory_depth (out.directory_depth)
);
